// ===== rtl/dtw_pkg.sv =====
// Shared types, sizes and arithmetic helpers for the DTW distance engine.
// No dependencies; every other RTL file but dtw_ram imports this package.
`default_nettype none

package dtw_pkg;

    // Sizes
    localparam int MAX_REF_LEN = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int DIST_W      = 32;
    localparam int ADDR_W      = $clog2(MAX_REF_LEN);
    localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int CMP_W       = (DIFF_W > DIST_W) ? DIFF_W : DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Operation codes
    localparam logic OP_REF   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Input beat
    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              ref_truncated;
        logic              ref_empty;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic              ref_wr;
        logic [ADDR_W-1:0] ref_addr;
        logic              sample_load;
        logic              issue;
        logic [ADDR_W-1:0] cell_addr;
        logic              first_cell;
        logic              last_cell;
        logic              first_row;
        logic              out_load;
        logic              ref_truncated;
        logic              ref_empty;
    } dtw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } dtw_status_t;

    // |a - b|, clamped to the distance range
    function automatic logic [DIST_W-1:0] cell_cost(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        logic [CMP_W-1:0]         mw;
        d  = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
        m  = d[DIFF_W-1] ? DIFF_W'(~d + 1'b1) : d;
        mw = CMP_W'(m);
        if (mw > CMP_W'(DIST_MAX))
            return DIST_MAX;
        return mw[DIST_W-1:0];
    endfunction

    // Saturating add
    function automatic logic [DIST_W-1:0] sat_add(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b
    );
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] min2(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtw_distance_engine.sv =====
// DTW distance engine top level; depends on dtw_pkg, dtw_ctrl, dtw_datapath.
// A query beat against a reference of L samples walks the row one cell per cycle, and the input
// stalls until the walk drains; a closing beat's result waits while an earlier result stalls.
// Reference load beats and query beats with an empty reference take no walk; a closing query
// beat with an empty reference goes straight to the result.
// Reset (rst_n, async, low) clears length, flags and sequencer; the stores are not cleared.
`default_nettype none

module dtw_distance_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire dtw_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output dtw_pkg::result_t      result
);
    import dtw_pkg::*;

    dtw_cmd_t    cmd;
    dtw_status_t status;

    dtw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    dtw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (item.sample),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/dtw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/dtw_datapath.sv =====
// DTW datapath: reference and row stores, three-stage cell pipeline, result register.
// Depends on dtw_pkg and dtw_ram.
`default_nettype none

module dtw_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dtw_pkg::dtw_cmd_t                     cmd,
    input  wire logic signed [dtw_pkg::SAMPLE_BITS-1:0] sample,
    output dtw_pkg::dtw_status_t                       status,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output dtw_pkg::result_t                           result
);
    import dtw_pkg::*;

    logic [SAMPLE_BITS-1:0]        ref_rd_data;
    logic [DIST_W-1:0]             row_rd_data;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // Stage 1: RAM read data valid
    logic              s1_vld_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // Stage 2: cost and min(up, diag) registered
    logic              s2_vld_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [DIST_W-1:0] cost_reg;
    logic [DIST_W-1:0] mdu_reg;

    logic [DIST_W-1:0] prev_up_reg;
    logic [DIST_W-1:0] left_reg;
    logic [DIST_W-1:0] dist_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic [DIST_W-1:0] up_eff;
    logic [DIST_W-1:0] diag_eff;
    logic [DIST_W-1:0] cost_s1;
    logic [DIST_W-1:0] left_eff;
    logic [DIST_W-1:0] cell_val;

    dtw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_REF_LEN)
    ) u_ref_ram (
        .clk     (clk),
        .wr_en   (cmd.ref_wr),
        .wr_addr (cmd.ref_addr),
        .wr_data (sample),
        .rd_en   (cmd.issue),
        .rd_addr (cmd.cell_addr),
        .rd_data (ref_rd_data)
    );

    dtw_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_REF_LEN)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (s2_vld_reg),
        .wr_addr (s2_addr_reg),
        .wr_data (cell_val),
        .rd_en   (cmd.issue),
        .rd_addr (cmd.cell_addr),
        .rd_data (row_rd_data)
    );

    // Stage 1 logic: on the first row there is no row above
    always_comb
    begin
        up_eff   = cmd.first_row ? DIST_MAX : row_rd_data;
        diag_eff = s1_first_reg ? DIST_MAX : prev_up_reg;
        cost_s1  = cell_cost(sample_reg, signed'(ref_rd_data));
    end

    // Stage 2 logic: first cell of a row has no left neighbor except the origin
    always_comb
    begin
        if (s2_first_reg)
            left_eff = cmd.first_row ? '0 : DIST_MAX;
        else
            left_eff = left_reg;
        cell_val = sat_add(min2(left_eff, mdu_reg), cost_reg);
    end

    // Pipeline and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
            sample_reg <= sample;
        if (cmd.issue)
        begin
            s1_first_reg <= cmd.first_cell;
            s1_last_reg  <= cmd.last_cell;
            s1_addr_reg  <= cmd.cell_addr;
        end
        if (s1_vld_reg)
        begin
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_addr_reg  <= s1_addr_reg;
            cost_reg     <= cost_s1;
            mdu_reg      <= min2(up_eff, diag_eff);
            prev_up_reg  <= up_eff;
        end
        if (s2_vld_reg)
        begin
            left_reg <= cell_val;
            if (s2_last_reg)
                dist_reg <= cell_val;
        end
        if (cmd.out_load)
        begin
            result_reg.distance      <= cmd.ref_empty ? '0 : dist_reg;
            result_reg.ref_truncated <= cmd.ref_truncated;
            result_reg.ref_empty     <= cmd.ref_empty;
        end
    end

    assign status.pipe_busy = s1_vld_reg | s2_vld_reg;
    assign status.out_full  = result_valid_reg;
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

endmodule

`default_nettype wire

// ===== rtl/dtw_ctrl.sv =====
// DTW controller: reference load bookkeeping, row walk sequencing, result hand-off.
// Depends on dtw_pkg.
`default_nettype none

module dtw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire dtw_pkg::item_t       item,
    input  wire logic                 result_stall,
    input  wire dtw_pkg::dtw_status_t status,
    output dtw_pkg::dtw_cmd_t         cmd
);
    import dtw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              open_reg, open_next;
    logic              first_row_reg, first_row_next;
    logic              trunc_reg, trunc_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              last_q_reg, last_q_next;

    logic              accept;
    logic              start;
    logic [LEN_W-1:0]  len_base;
    logic              room;
    logic [LEN_W-1:0]  len_m1;
    logic              last_cell;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // Reference write slot: a load that is not open restarts at zero
    assign start     = !open_reg;
    assign len_base  = start ? '0 : len_reg;
    assign room      = (len_base < LEN_W'(MAX_REF_LEN));
    assign len_m1    = len_reg - 1'b1;
    assign last_cell = (idx_reg == len_m1[ADDR_W-1:0]);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        open_next      = open_reg;
        first_row_next = first_row_reg;
        trunc_next     = trunc_reg;
        idx_next       = idx_reg;
        last_q_next    = last_q_reg;

        cmd               = '0;
        cmd.ref_addr      = len_base[ADDR_W-1:0];
        cmd.cell_addr     = idx_reg;
        cmd.first_cell    = (idx_reg == '0);
        cmd.last_cell     = last_cell;
        cmd.first_row     = first_row_reg;
        cmd.ref_truncated = trunc_reg;
        cmd.ref_empty     = (len_reg == '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_REF)
                    begin
                        cmd.ref_wr     = room;
                        len_next       = room ? len_base + 1'b1 : len_base;
                        trunc_next     = (start ? 1'b0 : trunc_reg) | !room;
                        open_next      = !item.last;
                        first_row_next = start ? 1'b1 : first_row_reg;
                    end
                    else
                    begin
                        open_next   = 1'b0;
                        last_q_next = item.last;
                        if (len_reg != '0)
                        begin
                            cmd.sample_load = 1'b1;
                            idx_next        = '0;
                            state_next      = S_WALK;
                        end
                        else if (item.last)
                        begin
                            first_row_next = 1'b1;
                            state_next     = S_DONE;
                        end
                    end
                end
            end
            S_WALK:
            begin
                cmd.issue = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (last_cell)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    first_row_next = last_q_reg;
                    state_next     = last_q_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (!status.out_full || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            open_reg      <= 1'b0;
            first_row_reg <= 1'b1;
            trunc_reg     <= 1'b0;
            idx_reg       <= '0;
            last_q_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            open_reg      <= open_next;
            first_row_reg <= first_row_next;
            trunc_reg     <= trunc_next;
            idx_reg       <= idx_next;
            last_q_reg    <= last_q_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtw_checker.sv =====
// Port-level checks for the DTW distance engine, bound to the top level.
// Depends on dtw_pkg and dtw_distance_engine.
`default_nettype none

module dtw_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire dtw_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire dtw_pkg::result_t result
);
    import dtw_pkg::*;

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Empty reference always reports zero distance
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ref_empty |-> result.distance == '0)
        else $error("empty reference with nonzero distance");

    // Only a closing query beat produces a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !(item.op == OP_QUERY && item.last)
        |=> !$rose(result_valid))
        else $error("result without a closing query beat");

    // A closing query beat keeps the input stalled while it completes
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.op == OP_QUERY && item.last |=> item_stall)
        else $error("input taken while closing query in flight");

endmodule

bind dtw_distance_engine dtw_checker u_dtw_checker (.*);

`default_nettype wire
